FILE: src/stl_pkg.sv
package stl_pkg;

  // Counter and nesting widths.
  localparam int unsigned LINE_BITS   = 24;
  localparam int unsigned COLUMN_BITS = 16;
  localparam int unsigned DEPTH_BITS  = 8;

  // Most result words that one source byte can cause.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned COUNT_BITS  = $clog2(MAX_RESULTS + 1);

  // Character codes the lexer reacts to.
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_QUOTE     = 8'h27;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_DIGIT0    = 8'h30;
  localparam logic [7:0] CH_DIGIT9    = 8'h39;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Codes of the number_single_char register.
  localparam logic [1:0] NSC_OTHER = 2'd0;
  localparam logic [1:0] NSC_SIGN  = 2'd1;
  localparam logic [1:0] NSC_DOT   = 2'd2;

  // Lexer mode, one-hot.
  typedef enum logic [9:0] {
    MODE_IDLE       = 10'b00_0000_0001,
    MODE_IDENT      = 10'b00_0000_0010,
    MODE_NUMBER     = 10'b00_0000_0100,
    MODE_STRING     = 10'b00_0000_1000,
    MODE_ESCAPE     = 10'b00_0001_0000,
    MODE_HASH       = 10'b00_0010_0000,
    MODE_LINECOM    = 10'b00_0100_0000,
    MODE_BLOCK      = 10'b00_1000_0000,
    MODE_BLOCK_HASH = 10'b01_0000_0000,
    MODE_BLOCK_BAR  = 10'b10_0000_0000
  } mode_e;

  // Token kinds as seen on the output.
  typedef enum logic [3:0] {
    KIND_PAREN  = 4'd0,
    KIND_QUOTE  = 4'd1,
    KIND_BOOL   = 4'd2,
    KIND_HASH   = 4'd3,
    KIND_NUMBER = 4'd4,
    KIND_IDENT  = 4'd5,
    KIND_DOT    = 4'd6,
    KIND_STRING = 4'd7,
    KIND_END    = 4'd8
  } kind_e;

  // Lexer state carried from one byte to the next.
  typedef struct packed {
    mode_e                  mode;
    logic [1:0]             single_char;
    logic                   length_over_one;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [DEPTH_BITS-1:0]  depth;
  } lex_state_t;

  // One result word.
  typedef struct packed {
    kind_e                  kind;
    logic [7:0]             text;
    logic                   has_byte;
    logic                   done;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } result_t;

endpackage

FILE: src/stl_decode.sv
module stl_decode (
  input  stl_pkg::lex_state_t                           state_i,
  input  logic [7:0]                                    char_i,
  input  logic                                          eoi_i,
  output stl_pkg::lex_state_t                           state_o,
  output stl_pkg::result_t [stl_pkg::MAX_RESULTS-1:0]   res_o,
  output logic [stl_pkg::COUNT_BITS-1:0]                count_o
);
  import stl_pkg::*;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return is_space(c) || c inside {CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_HASH, CH_SEMI};
  endfunction

  function automatic logic [LINE_BITS-1:0] adv_line(logic [LINE_BITS-1:0] l, logic [7:0] c);
    return (c == CH_NEWLINE && l != '1) ? l + LINE_BITS'(1) : l;
  endfunction

  function automatic logic [COLUMN_BITS-1:0] adv_col(logic [COLUMN_BITS-1:0] k,
                                                     logic [7:0] c);
    logic [COLUMN_BITS-1:0] r;
    if (c == CH_NEWLINE) begin
      r = '0;
    end else if (k != '1) begin
      r = k + COLUMN_BITS'(1);
    end else begin
      r = k;
    end
    return r;
  endfunction

  function automatic result_t mk(kind_e k, logic [7:0] t, logic h, logic d,
                                 logic [LINE_BITS-1:0] l, logic [COLUMN_BITS-1:0] c);
    result_t r;
    r.kind     = k;
    r.text     = h ? t : 8'h00;
    r.has_byte = h;
    r.done     = d;
    r.line     = l;
    r.column   = c;
    return r;
  endfunction

  // Final kind of a closing identifier or number word.
  function automatic kind_e word_kind(mode_e m, logic [1:0] sc, logic lo);
    kind_e k;
    k = KIND_IDENT;
    if (m == MODE_NUMBER) begin
      k = KIND_NUMBER;
      if (!lo && sc == NSC_SIGN) k = KIND_IDENT;
      if (!lo && sc == NSC_DOT)  k = KIND_DOT;
    end
    return k;
  endfunction

  mode_e                      mode;
  logic [1:0]                 sc;
  logic                       lo;
  logic [LINE_BITS-1:0]       line;
  logic [COLUMN_BITS-1:0]     col;
  logic [DEPTH_BITS-1:0]      depth;
  logic [COUNT_BITS-1:0]      n;
  result_t [MAX_RESULTS-1:0]  res;
  logic                       do_idle;
  logic                       do_str;
  logic [7:0]                 b;

  // One pass over the byte: the main mode step, then the shared string and
  // idle steps that several modes fall through to.
  always_comb begin
    mode    = state_i.mode;
    sc      = state_i.single_char;
    lo      = state_i.length_over_one;
    line    = state_i.line;
    col     = state_i.column;
    depth   = state_i.depth;
    n       = '0;
    res     = '0;
    do_idle = 1'b0;
    do_str  = 1'b0;
    b       = char_i;

    if (eoi_i) begin
      // Flush whatever is open, then the end token.
      case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          res[n] = mk(word_kind(mode, sc, lo), 8'h00, 1'b0, 1'b1, line, col);
          n = n + 1'b1;
        end
        MODE_ESCAPE: begin
          res[n] = mk(KIND_STRING, CH_BACKSLASH, 1'b1, 1'b0, line, col);
          n = n + 1'b1;
          res[n] = mk(KIND_STRING, 8'h00, 1'b0, 1'b1, line, col);
          n = n + 1'b1;
        end
        MODE_STRING: begin
          res[n] = mk(KIND_STRING, 8'h00, 1'b0, 1'b1, line, col);
          n = n + 1'b1;
        end
        MODE_HASH: begin
          res[n] = mk(KIND_HASH, CH_HASH, 1'b1, 1'b1, line, col);
          n = n + 1'b1;
        end
        default: ;
      endcase
      res[n] = mk(KIND_END, 8'h00, 1'b0, 1'b1, line, col);
      n = n + 1'b1;
      mode  = MODE_IDLE;
      depth = '0;
    end else begin
      case (mode)
        MODE_IDENT, MODE_NUMBER: begin
          if (is_delim(b)) begin
            res[n] = mk(word_kind(mode, sc, lo), 8'h00, 1'b0, 1'b1, line, col);
            n = n + 1'b1;
            do_idle = 1'b1;
          end else begin
            line = adv_line(line, b);
            col  = adv_col(col, b);
            if (mode == MODE_NUMBER) lo = 1'b1;
            res[n] = mk((mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT, b, 1'b1, 1'b0,
                        line, col);
            n = n + 1'b1;
          end
        end
        MODE_STRING: begin
          do_str = 1'b1;
        end
        MODE_ESCAPE: begin
          if (b == CH_DQUOTE || b == CH_BACKSLASH) begin
            line = adv_line(line, b);
            col  = adv_col(col, b);
            res[n] = mk(KIND_STRING, b, 1'b1, 1'b0, line, col);
            n = n + 1'b1;
            mode = MODE_STRING;
          end else begin
            res[n] = mk(KIND_STRING, CH_BACKSLASH, 1'b1, 1'b0, line, col);
            n = n + 1'b1;
            do_str = 1'b1;
          end
        end
        MODE_HASH: begin
          if (b == CH_BAR) begin
            line  = adv_line(line, b);
            col   = adv_col(col, b);
            depth = DEPTH_BITS'(1);
            mode  = MODE_BLOCK;
          end else if (b == CH_T || b == CH_F) begin
            res[n] = mk(KIND_BOOL, CH_HASH, 1'b1, 1'b0, line, col);
            n = n + 1'b1;
            res[n] = mk(KIND_BOOL, b, 1'b1, 1'b1, line, col);
            n = n + 1'b1;
            mode = MODE_IDLE;
          end else begin
            res[n] = mk(KIND_HASH, CH_HASH, 1'b1, 1'b1, line, col);
            n = n + 1'b1;
            do_idle = 1'b1;
          end
        end
        MODE_LINECOM: begin
          line = adv_line(line, b);
          col  = adv_col(col, b);
          if (b == CH_NEWLINE) mode = MODE_IDLE;
        end
        MODE_BLOCK, MODE_BLOCK_HASH, MODE_BLOCK_BAR: begin
          line = adv_line(line, b);
          col  = adv_col(col, b);
          if (mode == MODE_BLOCK_HASH && b == CH_BAR) begin
            if (depth != '1) depth = depth + DEPTH_BITS'(1);
            mode = MODE_BLOCK;
          end else if (mode == MODE_BLOCK_BAR && b == CH_HASH) begin
            if (depth != '0) depth = depth - DEPTH_BITS'(1);
            mode = (depth == '0) ? MODE_IDLE : MODE_BLOCK;
          end else if (b == CH_HASH) begin
            mode = MODE_BLOCK_HASH;
          end else if (b == CH_BAR) begin
            mode = MODE_BLOCK_BAR;
          end else begin
            mode = MODE_BLOCK;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // String body byte, also reached after a backslash that escapes nothing.
      if (do_str) begin
        if (b == CH_DQUOTE) begin
          res[n] = mk(KIND_STRING, 8'h00, 1'b0, 1'b1, line, col);
          n = n + 1'b1;
          mode = MODE_IDLE;
        end else if (b == CH_BACKSLASH) begin
          line = adv_line(line, b);
          col  = adv_col(col, b);
          mode = MODE_ESCAPE;
        end else begin
          line = adv_line(line, b);
          col  = adv_col(col, b);
          res[n] = mk(KIND_STRING, b, 1'b1, 1'b0, line, col);
          n = n + 1'b1;
          mode = MODE_STRING;
        end
      end

      // Byte seen between tokens; the opening quote of a string is not counted.
      if (do_idle) begin
        mode = MODE_IDLE;
        if (b == CH_DQUOTE) begin
          mode = MODE_STRING;
        end else begin
          line = adv_line(line, b);
          col  = adv_col(col, b);
          if (b == CH_SEMI) begin
            mode = MODE_LINECOM;
          end else if (b == CH_HASH) begin
            mode = MODE_HASH;
          end else if (b == CH_LPAREN || b == CH_RPAREN) begin
            res[n] = mk(KIND_PAREN, b, 1'b1, 1'b1, line, col);
            n = n + 1'b1;
          end else if (b == CH_QUOTE) begin
            res[n] = mk(KIND_QUOTE, b, 1'b1, 1'b1, line, col);
            n = n + 1'b1;
          end else if (b inside {[CH_DIGIT0:CH_DIGIT9], CH_PLUS, CH_MINUS, CH_DOT}) begin
            mode = MODE_NUMBER;
            if (b == CH_PLUS || b == CH_MINUS) begin
              sc = NSC_SIGN;
            end else if (b == CH_DOT) begin
              sc = NSC_DOT;
            end else begin
              sc = NSC_OTHER;
            end
            lo = 1'b0;
            res[n] = mk(KIND_NUMBER, b, 1'b1, 1'b0, line, col);
            n = n + 1'b1;
          end else if (!is_space(b)) begin
            mode = MODE_IDENT;
            res[n] = mk(KIND_IDENT, b, 1'b1, 1'b0, line, col);
            n = n + 1'b1;
          end
        end
      end
    end

    state_o.mode            = mode;
    state_o.single_char     = sc;
    state_o.length_over_one = lo;
    state_o.line            = line;
    state_o.column          = col;
    state_o.depth           = depth;
    res_o                   = res;
    count_o                 = n;
  end

endmodule

FILE: src/scheme_token_lexer.sv
// An accepted source byte waits in the input register until the single result bundle is
// free, then its decoded words are registered into that bundle, whose head is the output.
// Throughput: one byte per cycle while each byte yields at most one word and the output is
// ready; a byte with more words (up to three) holds input as they drain one a cycle.
// Reset (rst_ni low, asynchronous): mode idle, line 1, column 0, depth 0, no words held.
module scheme_token_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  logic        s_axis_tlast,  // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [7:0] text_byte, [31:8] line_number,
                                     // [47:32] column_number
  output logic [4:0]  m_axis_tuser,  // [3:0] token_kind, [4] has_byte
  output logic        m_axis_tlast   // token_done
);
  import stl_pkg::*;

  logic                      in_valid_q;
  logic [7:0]                in_char_q;
  logic                      in_eoi_q;
  lex_state_t                state_q, state_d;
  result_t [MAX_RESULTS-1:0] res_q, res_d;
  logic [COUNT_BITS-1:0]     cnt_q, cnt_d;
  logic                      consume;
  logic                      take;

  // Per-byte decode between the input register and the result bundle.
  stl_decode u_decode (
    .state_i (state_q),
    .char_i  (in_char_q),
    .eoi_i   (in_eoi_q),
    .state_o (state_d),
    .res_o   (res_d),
    .count_o (cnt_d)
  );

  // The held byte is decoded once the bundle is empty or gives up its last word.
  assign take    = (cnt_q != '0) && m_axis_tready;
  assign consume = in_valid_q &&
                   ((cnt_q == '0) || (cnt_q == COUNT_BITS'(1) && m_axis_tready));
  assign s_axis_tready = !in_valid_q || consume;

  // Input register control and lexer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q              <= 1'b0;
      state_q.mode            <= MODE_IDLE;
      state_q.single_char     <= NSC_OTHER;
      state_q.length_over_one <= 1'b0;
      state_q.line            <= LINE_BITS'(1);
      state_q.column          <= '0;
      state_q.depth           <= '0;
      cnt_q                   <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        state_q <= state_d;
        cnt_q   <= cnt_d;
      end else if (take) begin
        cnt_q <= cnt_q - COUNT_BITS'(1);
      end
    end
  end

  // Payload: input word and result bundle, shifted down as words leave.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tlast;
    end
    if (consume) begin
      res_q <= res_d;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        res_q[i] <= res_q[i+1];
      end
    end
  end

  // Output word is the head of the bundle.
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = {res_q[0].column, res_q[0].line, res_q[0].text};
  assign m_axis_tuser  = {res_q[0].has_byte, res_q[0].kind};
  assign m_axis_tlast  = res_q[0].done;

endmodule
